// ===== rtl/additive_feedback_prng_seed_and_draw_assert.svh =====
// Assertion macros used by the RTL controller (afpsd_ctrl).
`ifndef ADDITIVE_FEEDBACK_PRNG_SEED_AND_DRAW_ASSERT_SVH
`define ADDITIVE_FEEDBACK_PRNG_SEED_AND_DRAW_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define AFPSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afpsd: implication check failed");
// Next-cycle implication.
`define AFPSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afpsd: next-cycle check failed");
`else
`define AFPSD_ASSERT_IMP(lbl, ante, cons)
`define AFPSD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/afpsd_pkg.sv =====
package afpsd_pkg;

  localparam int SeedW  = 32;
  localparam int DrawW  = 31;
  localparam int DrawN  = 4;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 128;

  localparam int MulW  = 15;
  localparam int ProdW = MulW + SeedW;
  localparam logic [MulW-1:0]  LehmerMul = 15'd16807;
  localparam logic [SeedW-1:0] LehmerMod = 32'd2147483647;

  typedef struct packed {
    logic load_seed;
    logic mul;
    logic shift_lehmer;
    logic shift_copy;
    logic shift_sum;
    logic load_out;
  } afpsd_cmd_t;

  typedef struct packed {
    logic out_valid;
  } afpsd_status_t;

endpackage

// ===== rtl/afpsd_datapath.sv =====
module afpsd_datapath #(
  parameter int LONG_LAG  = 31,
  parameter int SHORT_LAG = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  afpsd_pkg::afpsd_cmd_t                cmd_i,
  output afpsd_pkg::afpsd_status_t             status_o,
  input  logic [afpsd_pkg::SeedW-1:0]          seed_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [afpsd_pkg::DrawN*afpsd_pkg::DrawW-1:0] draws_o
);
  import afpsd_pkg::*;

  localparam int Depth = (LONG_LAG > SHORT_LAG) ? LONG_LAG : SHORT_LAG;

  logic [SeedW-1:0] hist_q [Depth];
  logic [SeedW-1:0] hist_d [Depth];
  logic [ProdW-1:0] prod_q;
  logic [SeedW-1:0] fold;
  logic [SeedW-1:0] lehmer_val;
  logic [SeedW-1:0] new_val;
  logic             shift_en;
  logic             out_valid_q;
  logic [DrawN*DrawW-1:0] draws_q;

  always_comb begin
    fold = SeedW'(prod_q[ProdW-1:DrawW]) + SeedW'(prod_q[DrawW-1:0]);
    lehmer_val = (fold >= LehmerMod) ? (fold - LehmerMod) : fold;
  end

  always_comb begin
    priority if (cmd_i.load_seed) begin
      new_val = seed_i;
    end else if (cmd_i.shift_lehmer) begin
      new_val = lehmer_val;
    end else if (cmd_i.shift_copy) begin
      new_val = hist_q[LONG_LAG-1];
    end else begin
      new_val = hist_q[LONG_LAG-1] + hist_q[SHORT_LAG-1];
    end
    shift_en = cmd_i.load_seed | cmd_i.shift_lehmer | cmd_i.shift_copy | cmd_i.shift_sum;
    hist_d[0] = new_val;
    for (int j = 1; j < Depth; j++) begin
      hist_d[j] = hist_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      hist_q <= hist_d;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(LehmerMul) * ProdW'(hist_q[0]);
    end
    if (cmd_i.load_out) begin
      for (int k = 0; k < DrawN; k++) begin
        draws_q[k*DrawW +: DrawW] <= hist_q[DrawN-1-k][SeedW-1:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign draws_o = draws_q;

endmodule

// ===== rtl/afpsd_ctrl.sv =====
`include "additive_feedback_prng_seed_and_draw_assert.svh"

module afpsd_ctrl #(
  parameter int WARMUP_STEPS = 344,
  parameter int LONG_LAG     = 31,
  parameter int SHORT_LAG    = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  afpsd_pkg::afpsd_status_t status_i,
  output afpsd_pkg::afpsd_cmd_t    cmd_o
);
  import afpsd_pkg::*;

  localparam int LastIdx = WARMUP_STEPS + DrawN - 1;
  localparam int CntW    = $clog2(LastIdx + 1);
  localparam int CmpW    = (CntW > 7) ? CntW : 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_REC,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [CmpW-1:0] cnt_ext;
  logic            at_last;
  logic            next_lehmer;

  assign cnt_ext     = CmpW'(cnt_q);
  assign at_last     = (cnt_q == CntW'(LastIdx));
  assign next_lehmer = (cnt_ext < CmpW'(LONG_LAG - 1));
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load_seed = in_valid_i;
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_RED:  cmd_o.shift_lehmer = 1'b1;
      ST_REC: begin
        if (cnt_ext < CmpW'(LONG_LAG + SHORT_LAG)) begin
          cmd_o.shift_copy = 1'b1;
        end else begin
          cmd_o.shift_sum = 1'b1;
        end
      end
      ST_DONE: cmd_o.load_out = !status_i.out_valid;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= CntW'(1);
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_RED;
        ST_RED, ST_REC: begin
          if (at_last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= next_lehmer ? ST_MUL : ST_REC;
          end
        end
        ST_DONE: begin
          if (!status_i.out_valid) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `AFPSD_ASSERT_NXT(a_start, state_q == ST_IDLE && in_valid_i, state_q == ST_MUL && cnt_q == CntW'(1))
  `AFPSD_ASSERT_IMP(a_red_after_mul, state_q == ST_RED, $past(state_q) == ST_MUL)
  `AFPSD_ASSERT_IMP(a_load_free, cmd_o.load_out, !status_i.out_valid)
  `AFPSD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(LastIdx))

endmodule

// ===== rtl/additive_feedback_prng_seed_and_draw.sv =====
// Additive lagged-feedback generator, seed in, first four draws out.
// Input stream (s_axis): one 32-bit seed per transfer, taken only while the
// block is idle. Output stream (m_axis): one transfer per seed carrying four
// 31-bit draws.
// Per seed the controller walks the history one entry at a time: the seed,
// LONG_LAG-1 Lehmer entries (registered 15x32 multiply, then
// fold-and-subtract modulo 2^31-1), then copy or lagged sum entries up to
// index WARMUP_STEPS+3, then the output load. tvalid rises on the edge
// after the output load, and s_axis_tready comes back in the same cycle.
// The result sits in an output register, so the next seed is worked on while
// the result waits. If the receiver still holds off when the next result is
// done, the block waits with that result until the register frees.
// Reset clears the controller and the output valid flag; no history is kept
// between seeds.
module additive_feedback_prng_seed_and_draw #(
  parameter int WARMUP_STEPS = 344,
  parameter int LONG_LAG     = 31,
  parameter int SHORT_LAG    = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [afpsd_pkg::InTdataW-1:0]      s_axis_tdata_i,  // [31:0] seed_value
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [30:0] draw_zero, [61:31] draw_one, [92:62] draw_two, [123:93] draw_three
  output logic [afpsd_pkg::OutTdataW-1:0]     m_axis_tdata_o
);
  import afpsd_pkg::*;

  afpsd_cmd_t             cmd;
  afpsd_status_t          status;
  logic [DrawN*DrawW-1:0] draws;

  afpsd_ctrl #(
    .WARMUP_STEPS(WARMUP_STEPS),
    .LONG_LAG    (LONG_LAG),
    .SHORT_LAG   (SHORT_LAG)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  afpsd_datapath #(
    .LONG_LAG (LONG_LAG),
    .SHORT_LAG(SHORT_LAG)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .seed_i     (s_axis_tdata_i[SeedW-1:0]),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .draws_o    (draws)
  );

  assign m_axis_tdata_o = OutTdataW'(draws);

endmodule

// ===== test/tb_additive_feedback_prng_seed_and_draw.sv =====
`timescale 1ns / 1ps

module tb_additive_feedback_prng_seed_and_draw;
  import afpsd_pkg::*;

  localparam int WarmupSteps = 344;
  localparam int LongLag     = 31;
  localparam int ShortLag    = 3;
  localparam int HistDepth   = WarmupSteps + DrawN;
  localparam logic [63:0] MinstdMul = 64'd16807;
  localparam logic [63:0] MinstdMod = 64'd2147483647;
  localparam int unsigned CycleLimit = 12_000_000;
  localparam int DrainCycles = 400;

  typedef logic [DrawN-1:0][DrawW-1:0] draw_set_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  draw_set_t   draws_due[$];
  draw_set_t   next_due;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          steady = 1'b0;

  additive_feedback_prng_seed_and_draw dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic draw_set_t lagged_draws(input logic [SeedW-1:0] seed);
    logic [31:0] hist [HistDepth];
    logic [63:0] prod;
    draw_set_t   draws;
    hist[0] = seed;
    for (int i = 1; i < LongLag; i++) begin
      prod = MinstdMul * {32'd0, hist[i-1]};
      hist[i] = 32'(prod % MinstdMod);
    end
    for (int i = LongLag; i < LongLag + ShortLag; i++) begin
      hist[i] = hist[i-LongLag];
    end
    for (int i = LongLag + ShortLag; i < HistDepth; i++) begin
      hist[i] = hist[i-LongLag] + hist[i-ShortLag];
    end
    for (int k = 0; k < DrawN; k++) begin
      draws[k] = hist[WarmupSteps+k][31:1];
    end
    return draws;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // sender: random gaps, now and then a long one; valid stays up between
  // back-to-back transfers
  task automatic send_seed(input logic [SeedW-1:0] seed);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 11) gap++;
      if ($urandom_range(99) < 2) gap += $urandom_range(450);
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= seed;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    draws_due.push_back(lagged_draws(seed));
  endtask

  task automatic stop_seeds();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (draws_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SeedW-1:0] random_seed();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFF7 + $urandom_range(16);
      1: return $urandom_range(255);
      2: return 32'hFFFF_FFFF - $urandom_range(255);
      3: return 32'h0000_0001 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_edge_seeds();
    logic [SeedW-1:0] seeds [$];
    seeds = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_41A7,
              32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
              32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h0001_0000, 32'hFFFE_0001};
    foreach (seeds[i]) send_seed(seeds[i]);
  endtask

  // sender holds off until every pending result has been taken
  task automatic test_drain_pause();
    repeat (3) send_seed(random_seed());
    stop_seeds();
    wait_drained();
    repeat (3) send_seed(random_seed());
  endtask

  task automatic test_random_seeds(input int unsigned count);
    repeat (count) send_seed(random_seed());
  endtask

  task automatic test_back_to_back_seeds(input int unsigned count);
    steady = 1'b1;
    repeat (count) send_seed(random_seed());
    steady = 1'b0;
  endtask

  // receiver: random stalls plus rare long holds, which may outlast one seed's work
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (steady) begin
      m_axis_tready_i <= 1'b1;
    end else if ($urandom_range(4999) == 0) begin
      hold_left <= $urandom_range(900, 300);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (draws_due.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o[31:0], '0);
      end else begin
        next_due = draws_due.pop_front();
        for (int k = 0; k < DrawN; k++) begin
          if (m_axis_tdata_o[k*DrawW +: DrawW] !== next_due[k]) begin
            report_mismatch($sformatf("draw_%0d", k),
                            {1'b0, m_axis_tdata_o[k*DrawW +: DrawW]},
                            {1'b0, next_due[k]});
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[additive_feedback_prng_seed_and_draw] ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_seeds();
    test_drain_pause();
    test_random_seeds(1300);
    test_back_to_back_seeds(100);
    stop_seeds();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && draws_due.size() == 0) begin
      $display("[additive_feedback_prng_seed_and_draw] OK");
    end else begin
      $display("[additive_feedback_prng_seed_and_draw] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/afpsd_pkg.sv
rtl/afpsd_datapath.sv
rtl/afpsd_ctrl.sv
rtl/additive_feedback_prng_seed_and_draw.sv
test/tb_additive_feedback_prng_seed_and_draw.sv
